/* design/lav_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths, constants and types of the look-at view matrix unit.
// ----------------------------------------------------------------------------
package lav_pkg;

   localparam int FIX_W      = 32;   // Q16.16 word
   localparam int FRAC_W     = 16;
   localparam int UNIT_W     = 18;   // unit vector component, |v| <= 1.0
   localparam int VEC_W      = 52;   // normalizer input component
   localparam int MAG_W      = 31;   // component after range shift
   localparam int SHIFT_W    = 5;
   localparam int BITLEN_W   = 6;
   localparam int SUM_W      = 64;
   localparam int SQRT_STEPS = 32;
   localparam int LEN_W      = 32;
   localparam int QUO_W      = 17;
   localparam int REM_W      = 49;
   localparam int ROW_W      = 2;

   localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;
   localparam logic [FIX_W-1:0] ONE_Q16  = 32'h0001_0000;

   typedef struct packed {
      logic [2:0][FIX_W-1:0]  cam;
      logic [2:0][FIX_W-1:0]  up;
      logic [2:0][UNIT_W-1:0] z;
      logic                   degen;
   } side_type;

endpackage

/* design/look_at_view_matrix_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// Right-handed look-at view matrix in Q16.16, emitted as four row transactions.
// ----------------------------------------------------------------------------
// One transaction in (camera, target, up) gives four row transactions out,
// row 0 first, last_row on row 3. The datapath is a single pipeline of
// 119 register stages (two normalizers, each with a 32-stage square
// root and a 17-stage divider, plus cross and dot product stages), which
// takes new transactions while earlier ones are in flight. Sustained
// throughput is set by the output register that hands out the four rows of
// a matrix. The whole pipeline holds while the output register is busy and
// its last stage carries a matrix.
module look_at_view_matrix_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [lav_pkg::FIX_W-1:0]   req_cam_x,
   input  logic signed [lav_pkg::FIX_W-1:0]   req_cam_y,
   input  logic signed [lav_pkg::FIX_W-1:0]   req_cam_z,
   input  logic signed [lav_pkg::FIX_W-1:0]   req_target_x,
   input  logic signed [lav_pkg::FIX_W-1:0]   req_target_y,
   input  logic signed [lav_pkg::FIX_W-1:0]   req_target_z,
   input  logic signed [lav_pkg::FIX_W-1:0]   req_up_x,
   input  logic signed [lav_pkg::FIX_W-1:0]   req_up_y,
   input  logic signed [lav_pkg::FIX_W-1:0]   req_up_z,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lav_pkg::ROW_W-1:0]          rsp_row_index,
   output logic signed [lav_pkg::FIX_W-1:0]   rsp_entry0,
   output logic signed [lav_pkg::FIX_W-1:0]   rsp_entry1,
   output logic signed [lav_pkg::FIX_W-1:0]   rsp_entry2,
   output logic signed [lav_pkg::FIX_W-1:0]   rsp_entry3,
   output logic                               rsp_degenerate,
   output logic                               rsp_last_row
);
   import lav_pkg::*;

   localparam int PX_W = FIX_W + UNIT_W;
   localparam int PY_W = 2 * UNIT_W;
   localparam int PD_W = 2 * FIX_W;

   // Q32.32 to Q16.16, halves away from zero, optional negate, saturate
   function automatic logic [FIX_W-1:0] rnd_sat(input logic [PD_W-1:0] v,
                                                 input logic flip);
      logic [PD_W-1:0] m;
      logic            sgn;
      sgn = v[PD_W-1] ^ flip;
      m   = v[PD_W-1] ? (~v + PD_W'(1)) : v;
      m   = (m + (PD_W'(1) << (FRAC_W - 1))) >> FRAC_W;
      if (sgn) begin
         rnd_sat = (m > PD_W'(64'h8000_0000)) ? 32'h8000_0000 : FIX_W'(~m + PD_W'(1));
      end else begin
         rnd_sat = (m > PD_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : FIX_W'(m);
      end
   endfunction

   logic adv;
   logic out_free;
   logic fin_val_ff;

   assign adv       = !fin_val_ff || out_free;
   assign req_stall = !adv;

   // input register
   logic signed [FIX_W-1:0] cam_ff [3];
   logic signed [FIX_W-1:0] tgt_ff [3];
   logic signed [FIX_W-1:0] up_ff  [3];
   logic                    val0_ff;

   always_ff @(posedge clock) begin
      if (reset) val0_ff <= 1'b0;
      else if (adv) val0_ff <= req_valid;
      if (adv) begin
         cam_ff[0] <= req_cam_x;
         cam_ff[1] <= req_cam_y;
         cam_ff[2] <= req_cam_z;
         tgt_ff[0] <= req_target_x;
         tgt_ff[1] <= req_target_y;
         tgt_ff[2] <= req_target_z;
         up_ff[0]  <= req_up_x;
         up_ff[1]  <= req_up_y;
         up_ff[2]  <= req_up_z;
      end
   end

   // z axis
   logic [2:0][VEC_W-1:0]  n1_in_vec;
   side_type               n1_in_side;
   logic                   n1_valid;
   logic [2:0][UNIT_W-1:0] n1_vec;
   logic                   n1_bad;
   side_type               n1_side;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1_in_vec[i]     = VEC_W'(cam_ff[i]) - VEC_W'(tgt_ff[i]);
         n1_in_side.cam[i] = cam_ff[i];
         n1_in_side.up[i]  = up_ff[i];
      end
      n1_in_side.z     = '0;
      n1_in_side.degen = 1'b0;
   end

   lav_norm u_norm_z (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (val0_ff),
      .in_vec    (n1_in_vec),
      .in_side   (n1_in_side),
      .out_valid (n1_valid),
      .out_vec   (n1_vec),
      .out_bad   (n1_bad),
      .out_side  (n1_side)
   );

   // up cross z products
   logic signed [PX_W-1:0] px_ff [6];
   side_type               sx_ff;
   logic                   valx_ff;

   always_ff @(posedge clock) begin
      if (reset) valx_ff <= 1'b0;
      else if (adv) valx_ff <= n1_valid;
      if (adv) begin
         px_ff[0] <= $signed(n1_side.up[1]) * $signed(n1_vec[2]);
         px_ff[1] <= $signed(n1_side.up[2]) * $signed(n1_vec[1]);
         px_ff[2] <= $signed(n1_side.up[2]) * $signed(n1_vec[0]);
         px_ff[3] <= $signed(n1_side.up[0]) * $signed(n1_vec[2]);
         px_ff[4] <= $signed(n1_side.up[0]) * $signed(n1_vec[1]);
         px_ff[5] <= $signed(n1_side.up[1]) * $signed(n1_vec[0]);
         sx_ff.cam   <= n1_side.cam;
         sx_ff.up    <= n1_side.up;
         sx_ff.z     <= n1_vec;
         sx_ff.degen <= n1_bad;
      end
   end

   // x axis
   logic [2:0][VEC_W-1:0]  n2_in_vec;
   logic                   n2_valid;
   logic [2:0][UNIT_W-1:0] n2_vec;
   logic                   n2_bad;
   side_type               n2_side;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n2_in_vec[i] = VEC_W'(px_ff[2*i]) - VEC_W'(px_ff[2*i+1]);
      end
   end

   lav_norm u_norm_x (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (valx_ff),
      .in_vec    (n2_in_vec),
      .in_side   (sx_ff),
      .out_valid (n2_valid),
      .out_vec   (n2_vec),
      .out_bad   (n2_bad),
      .out_side  (n2_side)
   );

   // z cross x products
   logic signed [PY_W-1:0]   py_ff  [6];
   logic signed [UNIT_W-1:0] x1_ff  [3];
   logic signed [UNIT_W-1:0] z1_ff  [3];
   logic signed [FIX_W-1:0]  cam1_ff [3];
   logic                     dg1_ff;
   logic                     val1_ff;

   always_ff @(posedge clock) begin
      if (reset) val1_ff <= 1'b0;
      else if (adv) val1_ff <= n2_valid;
      if (adv) begin
         py_ff[0] <= $signed(n2_side.z[1]) * $signed(n2_vec[2]);
         py_ff[1] <= $signed(n2_side.z[2]) * $signed(n2_vec[1]);
         py_ff[2] <= $signed(n2_side.z[2]) * $signed(n2_vec[0]);
         py_ff[3] <= $signed(n2_side.z[0]) * $signed(n2_vec[2]);
         py_ff[4] <= $signed(n2_side.z[0]) * $signed(n2_vec[1]);
         py_ff[5] <= $signed(n2_side.z[1]) * $signed(n2_vec[0]);
         for (int i = 0; i < 3; i++) begin
            x1_ff[i]   <= $signed(n2_vec[i]);
            z1_ff[i]   <= $signed(n2_side.z[i]);
            cam1_ff[i] <= $signed(n2_side.cam[i]);
         end
         dg1_ff <= n2_side.degen | n2_bad;
      end
   end

   // y axis
   logic signed [FIX_W-1:0]  y2_ff   [3];
   logic signed [UNIT_W-1:0] x2_ff   [3];
   logic signed [UNIT_W-1:0] z2_ff   [3];
   logic signed [FIX_W-1:0]  cam2_ff [3];
   logic                     dg2_ff;
   logic                     val2_ff;

   always_ff @(posedge clock) begin
      if (reset) val2_ff <= 1'b0;
      else if (adv) val2_ff <= val1_ff;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            y2_ff[i]   <= rnd_sat(PD_W'(py_ff[2*i]) - PD_W'(py_ff[2*i+1]), 1'b0);
            x2_ff[i]   <= x1_ff[i];
            z2_ff[i]   <= z1_ff[i];
            cam2_ff[i] <= cam1_ff[i];
         end
         dg2_ff <= dg1_ff;
      end
   end

   // dot product terms
   logic signed [PD_W-1:0]  pdx_ff [3];
   logic signed [PD_W-1:0]  pdy_ff [3];
   logic signed [PD_W-1:0]  pdz_ff [3];
   logic signed [FIX_W-1:0] x3_ff  [3];
   logic signed [FIX_W-1:0] y3_ff  [3];
   logic signed [FIX_W-1:0] z3_ff  [3];
   logic                    dg3_ff;
   logic                    val3_ff;

   always_ff @(posedge clock) begin
      if (reset) val3_ff <= 1'b0;
      else if (adv) val3_ff <= val2_ff;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pdx_ff[i] <= x2_ff[i] * cam2_ff[i];
            pdy_ff[i] <= y2_ff[i] * cam2_ff[i];
            pdz_ff[i] <= z2_ff[i] * cam2_ff[i];
            x3_ff[i]  <= FIX_W'(x2_ff[i]);
            y3_ff[i]  <= y2_ff[i];
            z3_ff[i]  <= FIX_W'(z2_ff[i]);
         end
         dg3_ff <= dg2_ff;
      end
   end

   // finished matrix
   logic [FIX_W-1:0] fx_ff [3];
   logic [FIX_W-1:0] fy_ff [3];
   logic [FIX_W-1:0] fz_ff [3];
   logic [FIX_W-1:0] fd_ff [3];
   logic             fdg_ff;

   always_ff @(posedge clock) begin
      if (reset) fin_val_ff <= 1'b0;
      else if (adv) fin_val_ff <= val3_ff;
      if (adv) begin
         fd_ff[0] <= rnd_sat(PD_W'(pdx_ff[0] + pdx_ff[1] + pdx_ff[2]), 1'b1);
         fd_ff[1] <= rnd_sat(PD_W'(pdy_ff[0] + pdy_ff[1] + pdy_ff[2]), 1'b1);
         fd_ff[2] <= rnd_sat(PD_W'(pdz_ff[0] + pdz_ff[1] + pdz_ff[2]), 1'b1);
         for (int i = 0; i < 3; i++) begin
            fx_ff[i] <= x3_ff[i];
            fy_ff[i] <= y3_ff[i];
            fz_ff[i] <= z3_ff[i];
         end
         fdg_ff <= dg3_ff;
      end
   end

   // row output register
   logic [FIX_W-1:0] ox_ff [3];
   logic [FIX_W-1:0] oy_ff [3];
   logic [FIX_W-1:0] oz_ff [3];
   logic [FIX_W-1:0] od_ff [3];
   logic             odg_ff;
   logic             oval_ff;
   logic [ROW_W-1:0] row_ff;

   assign out_free = !oval_ff || (row_ff == LAST_ROW && !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         oval_ff <= 1'b0;
         row_ff  <= '0;
      end else if (out_free) begin
         oval_ff <= fin_val_ff;
         row_ff  <= '0;
      end else if (!rsp_stall) begin
         row_ff <= row_ff + ROW_W'(1);
      end
      if (out_free) begin
         ox_ff  <= fx_ff;
         oy_ff  <= fy_ff;
         oz_ff  <= fz_ff;
         od_ff  <= fd_ff;
         odg_ff <= fdg_ff;
      end
   end

   always_comb begin
      if (row_ff == LAST_ROW) begin
         rsp_entry0 = od_ff[0];
         rsp_entry1 = od_ff[1];
         rsp_entry2 = od_ff[2];
         rsp_entry3 = ONE_Q16;
      end else begin
         rsp_entry0 = ox_ff[row_ff];
         rsp_entry1 = oy_ff[row_ff];
         rsp_entry2 = oz_ff[row_ff];
         rsp_entry3 = '0;
      end
   end

   assign rsp_valid      = oval_ff;
   assign rsp_row_index  = row_ff;
   assign rsp_degenerate = odg_ff;
   assign rsp_last_row   = (row_ff == LAST_ROW);

endmodule

/* design/lav_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: range shift, sum of squares, 32-step
// integer square root, 17-step rounded division per component.
// ----------------------------------------------------------------------------
module lav_norm (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    adv,
   input  logic                                    in_valid,
   input  logic [2:0][lav_pkg::VEC_W-1:0]          in_vec,
   input  lav_pkg::side_type                       in_side,
   output logic                                    out_valid,
   output logic [2:0][lav_pkg::UNIT_W-1:0]         out_vec,
   output logic                                    out_bad,
   output lav_pkg::side_type                       out_side
);
   import lav_pkg::*;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] a;
      logic [2:0]            neg;
      side_type              side;
   } carry_type;

   // input register
   logic [2:0][VEC_W-1:0] v0_ff;
   side_type              side0_ff;
   logic                  val0_ff;

   always_ff @(posedge clock) begin
      if (reset) val0_ff <= 1'b0;
      else if (adv) val0_ff <= in_valid;
      if (adv) begin
         v0_ff    <= in_vec;
         side0_ff <= in_side;
      end
   end

   // magnitudes and maximum
   logic [2:0][VEC_W-1:0] m1_in, m1_ff;
   logic [2:0]            neg1_in, neg1_ff;
   logic [VEC_W-1:0]      mx1_in, mx1_ff;
   side_type              side1_ff;
   logic                  val1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = v0_ff[i][VEC_W-1];
         m1_in[i]   = neg1_in[i] ? (~v0_ff[i] + VEC_W'(1)) : v0_ff[i];
      end
      mx1_in = m1_in[0];
      if (m1_in[1] > mx1_in) mx1_in = m1_in[1];
      if (m1_in[2] > mx1_in) mx1_in = m1_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) val1_ff <= 1'b0;
      else if (adv) val1_ff <= val0_ff;
      if (adv) begin
         m1_ff    <= m1_in;
         neg1_ff  <= neg1_in;
         mx1_ff   <= mx1_in;
         side1_ff <= side0_ff;
      end
   end

   // range shift amount
   logic [BITLEN_W-1:0]   bl;
   logic [SHIFT_W-1:0]    sh2_in, sh2_ff;
   logic [2:0][VEC_W-1:0] m2_ff;
   logic [2:0]            neg2_ff;
   side_type              side2_ff;
   logic                  val2_ff;

   always_comb begin
      bl = '0;
      for (int i = 0; i < VEC_W; i++) begin
         if (mx1_ff[i]) bl = BITLEN_W'(i + 1);
      end
      sh2_in = (bl > BITLEN_W'(MAG_W)) ? SHIFT_W'(bl - BITLEN_W'(MAG_W)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) val2_ff <= 1'b0;
      else if (adv) val2_ff <= val1_ff;
      if (adv) begin
         sh2_ff   <= sh2_in;
         m2_ff    <= m1_ff;
         neg2_ff  <= neg1_ff;
         side2_ff <= side1_ff;
      end
   end

   // shifted components
   carry_type c3_in, c3_ff;
   logic      val3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) c3_in.a[i] = MAG_W'(m2_ff[i] >> sh2_ff);
      c3_in.neg  = neg2_ff;
      c3_in.side = side2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) val3_ff <= 1'b0;
      else if (adv) val3_ff <= val2_ff;
      if (adv) c3_ff <= c3_in;
   end

   // squares
   logic [2:0][2*MAG_W-1:0] sq4_ff;
   carry_type               c4_ff;
   logic                    val4_ff;

   always_ff @(posedge clock) begin
      if (reset) val4_ff <= 1'b0;
      else if (adv) val4_ff <= val3_ff;
      if (adv) begin
         for (int i = 0; i < 3; i++) sq4_ff[i] <= c3_ff.a[i] * c3_ff.a[i];
         c4_ff <= c3_ff;
      end
   end

   // square root, one result bit per stage
   logic [SUM_W-1:0] rem_ff [SQRT_STEPS+1];
   logic [SUM_W-1:0] res_ff [SQRT_STEPS+1];
   carry_type        cs_ff  [SQRT_STEPS+1];
   logic             sv_ff  [SQRT_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) sv_ff[0] <= 1'b0;
      else if (adv) sv_ff[0] <= val4_ff;
      if (adv) begin
         rem_ff[0] <= SUM_W'(sq4_ff[0]) + SUM_W'(sq4_ff[1]) + SUM_W'(sq4_ff[2]);
         res_ff[0] <= '0;
         cs_ff[0]  <= c4_ff;
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [SUM_W-1:0] trial;
      assign trial = res_ff[k] + BIT;

      always_ff @(posedge clock) begin
         if (reset) sv_ff[k+1] <= 1'b0;
         else if (adv) sv_ff[k+1] <= sv_ff[k];
         if (adv) begin
            cs_ff[k+1] <= cs_ff[k];
            if (rem_ff[k] >= trial) begin
               rem_ff[k+1] <= rem_ff[k] - trial;
               res_ff[k+1] <= (res_ff[k] >> 1) + BIT;
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               res_ff[k+1] <= res_ff[k] >> 1;
            end
         end
      end
   end

   // rounded division, one quotient bit per stage
   logic [2:0][REM_W-1:0] dr_ff [QUO_W];
   logic [2:0][QUO_W-1:0] dq_ff [QUO_W];
   logic [LEN_W-1:0]      dl_ff [QUO_W];
   carry_type             dc_ff [QUO_W];
   logic                  dv_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      logic [2:0][REM_W-1:0] r_src, r_nxt;
      logic [2:0][QUO_W-1:0] q_src, q_nxt;
      logic [LEN_W-1:0]      len_src;
      carry_type             c_src;
      logic                  v_src;
      logic [REM_W-1:0]      dsr;

      if (j == 0) begin : g_first
         assign len_src = res_ff[SQRT_STEPS][LEN_W-1:0];
         assign c_src   = cs_ff[SQRT_STEPS];
         assign v_src   = sv_ff[SQRT_STEPS];
         assign q_src   = '0;
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               r_src[i] = REM_W'({c_src.a[i], FRAC_W'(0)}) + REM_W'(len_src >> 1);
            end
         end
      end else begin : g_next
         assign len_src = dl_ff[j-1];
         assign c_src   = dc_ff[j-1];
         assign v_src   = dv_ff[j-1];
         assign q_src   = dq_ff[j-1];
         assign r_src   = dr_ff[j-1];
      end

      assign dsr = REM_W'(len_src) << (QUO_W - 1 - j);

      always_comb begin
         r_nxt = r_src;
         q_nxt = q_src;
         for (int i = 0; i < 3; i++) begin
            if (r_src[i] >= dsr) begin
               r_nxt[i]              = r_src[i] - dsr;
               q_nxt[i][QUO_W-1-j]   = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_ff[j] <= 1'b0;
         else if (adv) dv_ff[j] <= v_src;
         if (adv) begin
            dr_ff[j] <= r_nxt;
            dq_ff[j] <= q_nxt;
            dl_ff[j] <= len_src;
            dc_ff[j] <= c_src;
         end
      end
   end

   // sign restore, zero length
   logic [2:0][UNIT_W-1:0] vec_in, vec_ff;
   logic                   bad_in, bad_ff;
   side_type               sideo_ff;
   logic                   valo_ff;

   always_comb begin
      bad_in = (dl_ff[QUO_W-1] == '0);
      for (int i = 0; i < 3; i++) begin
         if (bad_in) vec_in[i] = '0;
         else if (dc_ff[QUO_W-1].neg[i]) vec_in[i] = -{1'b0, dq_ff[QUO_W-1][i]};
         else vec_in[i] = {1'b0, dq_ff[QUO_W-1][i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valo_ff <= 1'b0;
      else if (adv) valo_ff <= dv_ff[QUO_W-1];
      if (adv) begin
         vec_ff   <= vec_in;
         bad_ff   <= bad_in;
         sideo_ff <= dc_ff[QUO_W-1].side;
      end
   end

   assign out_valid = valo_ff;
   assign out_vec   = vec_ff;
   assign out_bad   = bad_ff;
   assign out_side  = sideo_ff;

endmodule
